### rtl/encoder_bank_scanner_assert.svh
// assertion macros shared by the scanner modules
// expects clk and rst in the scope of each use
`ifndef ENCODER_BANK_SCANNER_ASSERT_SVH
`define ENCODER_BANK_SCANNER_ASSERT_SVH

// condition holds at every edge outside reset
`define EBS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define EBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ebs_pkg.sv
// shared constants, register codes and config struct of the encoder bank scanner
// no dependencies
package ebs_pkg;

  localparam int ENCODERS_DEF = 5;
  localparam int PIN_BITS_DEF = 16;
  localparam int QUEUE_DEPTH  = 4;

  localparam int SNAP_W  = 16;
  localparam int SEL_W   = 20;
  localparam int FLUSH_W = 16;
  localparam int CNT_W   = 16;
  localparam int IDX_W   = 3;
  localparam int PIN_IDX_W = 4;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [SEL_W-1:0]   A_SEL_RST  = 20'd824880;
  localparam logic [SEL_W-1:0]   B_SEL_RST  = 20'd894785;
  localparam logic [SEL_W-1:0]   SW_SEL_RST = 20'd964690;
  localparam logic [FLUSH_W-1:0] FLUSH_RST  = 16'd200;

  localparam logic EVT_ROTATION = 1'b0;
  localparam logic EVT_SWITCH   = 1'b1;

  typedef enum logic [1:0] {
    REG_A_SEL  = 2'd0,
    REG_B_SEL  = 2'd1,
    REG_SW_SEL = 2'd2,
    REG_FLUSH  = 2'd3
  } ebs_reg_e;

  typedef struct packed {
    logic [SEL_W-1:0]   a_sel;
    logic [SEL_W-1:0]   b_sel;
    logic [SEL_W-1:0]   sw_sel;
    logic [FLUSH_W-1:0] flush;
  } ebs_cfg_t;

endpackage

### rtl/ebs_if.sv
// word channels of the scanner: tick snapshots in, events out
// depends on ebs_pkg for field widths
interface ebs_tick_if;
  logic                        valid;
  logic                        ready;
  logic [ebs_pkg::SNAP_W-1:0]  pin_snapshot;

  modport source (output valid, output pin_snapshot, input ready);
  modport sink (input valid, input pin_snapshot, output ready);
endinterface

interface ebs_event_if;
  logic                              valid;
  logic                              ready;
  logic                              event_kind;
  logic [ebs_pkg::IDX_W-1:0]         encoder_index;
  logic signed [ebs_pkg::CNT_W-1:0]  step_count;
  logic                              last_event;

  modport source (output valid, output event_kind, output encoder_index,
                  output step_count, output last_event, input ready);
  modport sink (input valid, input event_kind, input encoder_index,
                input step_count, input last_event, output ready);
endinterface

### rtl/ebs_fifo.sv
// small register queue of per-tick event plans between front and back
// depends on the assertion macro header
`include "encoder_bank_scanner_assert.svh"

module ebs_fifo #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : AW'(wptr + 1'b1);
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : AW'(rptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  `EBS_ASSERT_ALWAYS(a_no_overflow, !(push && full && !pop), "push into full queue")
  `EBS_ASSERT_ALWAYS(a_no_underflow, !(pop && empty), "pop from empty queue")

endmodule

### rtl/ebs_front.sv
// front end: takes tick words, steps the counters, decides the events of each tick
// depends on ebs_pkg, ebs_if and the assertion macro header
`include "encoder_bank_scanner_assert.svh"

module ebs_front #(
  parameter int ENCODERS = ebs_pkg::ENCODERS_DEF,
  parameter int PIN_BITS = ebs_pkg::PIN_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  ebs_tick_if.sink             tick,
  input  ebs_pkg::ebs_cfg_t    cfg,
  input  logic                 full,
  output logic                 push,
  output logic [ENCODERS*(2+ebs_pkg::CNT_W)-1:0] entry
);

  localparam logic [ebs_pkg::SNAP_W-1:0] PinMask =
    ebs_pkg::SNAP_W'((32'd1 << PIN_BITS) - 32'd1);

  logic [ebs_pkg::SNAP_W-1:0]                 prev;
  logic                                       primed;
  logic [ENCODERS-1:0][ebs_pkg::CNT_W-1:0]    cnt;
  logic [ebs_pkg::FLUSH_W-1:0]                idle;

  logic [ebs_pkg::SNAP_W-1:0]                 now;
  logic [ebs_pkg::SNAP_W-1:0]                 rising;
  logic [ENCODERS-1:0]                        step;
  logic [ENCODERS-1:0]                        sw;
  logic [ENCODERS-1:0]                        rot;
  logic [ENCODERS-1:0][ebs_pkg::CNT_W-1:0]    cnt_step;
  logic [ebs_pkg::FLUSH_W-1:0]                idle_next;
  logic                                       flush;
  logic                                       accept;

  assign tick.ready = !full;
  assign accept     = tick.valid && tick.ready;

  always_comb begin
    logic [ebs_pkg::PIN_IDX_W-1:0] ai;
    logic [ebs_pkg::PIN_IDX_W-1:0] bi;
    logic [ebs_pkg::PIN_IDX_W-1:0] si;
    now    = tick.pin_snapshot & PinMask;
    rising = now & ~prev;
    for (int e = 0; e < ENCODERS; e++) begin
      ai = cfg.a_sel[4*e +: 4];
      bi = cfg.b_sel[4*e +: 4];
      si = cfg.sw_sel[4*e +: 4];
      step[e] = rising[bi];
      sw[e]   = rising[si];
      if (!step[e]) begin
        cnt_step[e] = cnt[e];
      end else if (!now[ai]) begin
        cnt_step[e] = ebs_pkg::CNT_W'(cnt[e] + 1'b1);
      end else begin
        cnt_step[e] = ebs_pkg::CNT_W'(cnt[e] - 1'b1);
      end
    end
    idle_next = ebs_pkg::FLUSH_W'(((|step) ? '0 : idle) + 1'b1);
    flush     = (idle_next >= cfg.flush);
    for (int e = 0; e < ENCODERS; e++) begin
      rot[e] = flush && (cnt_step[e] != '0);
    end
  end

  assign push  = accept && primed && ((|sw) || (|rot));
  assign entry = {cnt_step, rot, sw};

  always_ff @(posedge clk) begin
    if (rst) begin
      prev   <= '0;
      primed <= 1'b0;
      cnt    <= '0;
      idle   <= '0;
    end else if (accept) begin
      prev   <= now;
      primed <= 1'b1;
      if (primed) begin
        cnt  <= flush ? '0 : cnt_step;
        idle <= flush ? '0 : idle_next;
      end
    end
  end

  `EBS_ASSERT_NEXT(a_primed_after_tick, accept, primed, "tick taken but not primed")
  `EBS_ASSERT_NEXT(a_flush_restarts_idle, accept && primed && flush, idle == '0, "idle not restarted")

endmodule

### rtl/ebs_back.sv
// back end: walks one tick's event plan and sends one event word per cycle while the receiver is ready
// depends on ebs_pkg, ebs_if and the assertion macro header
`include "encoder_bank_scanner_assert.svh"

module ebs_back #(
  parameter int ENCODERS = ebs_pkg::ENCODERS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [ENCODERS*(2+ebs_pkg::CNT_W)-1:0] qdata,
  input  logic                 empty,
  output logic                 pop,
  ebs_event_if.source          evt
);

  localparam int IW = (ENCODERS > 1) ? $clog2(ENCODERS) : 1;

  logic                                     busy;
  logic [ENCODERS-1:0]                      cur_sw;
  logic [ENCODERS-1:0]                      cur_rot;
  logic [ENCODERS-1:0][ebs_pkg::CNT_W-1:0]  cur_cnt;
  logic                                     ovalid;

  logic                 use_sw;
  logic [ENCODERS-1:0]  src;
  logic [IW-1:0]        pick;
  logic [ENCODERS-1:0]  sw_left;
  logic [ENCODERS-1:0]  rot_left;
  logic                 is_last;
  logic                 adv;
  logic                 load;

  always_comb begin
    use_sw = |cur_sw;
    src    = use_sw ? cur_sw : cur_rot;
    pick   = '0;
    for (int e = ENCODERS - 1; e >= 0; e--) begin
      if (src[e]) begin
        pick = IW'(e);
      end
    end
    sw_left  = cur_sw;
    rot_left = cur_rot;
    if (use_sw) begin
      sw_left[pick] = 1'b0;
    end else begin
      rot_left[pick] = 1'b0;
    end
    is_last = !(|sw_left) && !(|rot_left);
    adv     = busy && (!ovalid || evt.ready);
    load    = (!busy || (adv && is_last)) && !empty;
  end

  assign pop       = load;
  assign evt.valid = ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
      end else if (adv && is_last) begin
        busy <= 1'b0;
      end
      if (adv) begin
        ovalid <= 1'b1;
      end else if (evt.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      {cur_cnt, cur_rot, cur_sw} <= qdata;
    end else if (adv) begin
      cur_sw  <= sw_left;
      cur_rot <= rot_left;
    end
    if (adv) begin
      evt.event_kind    <= use_sw ? ebs_pkg::EVT_SWITCH : ebs_pkg::EVT_ROTATION;
      evt.encoder_index <= ebs_pkg::IDX_W'(pick);
      evt.step_count    <= use_sw ? '0 : cur_cnt[pick];
      evt.last_event    <= is_last;
    end
  end

  `EBS_ASSERT_ALWAYS(a_busy_has_work, !busy || (|cur_sw) || (|cur_rot), "busy with empty plan")
  `EBS_ASSERT_NEXT(a_last_frees, adv && is_last && empty, !busy, "plan not retired after last word")

endmodule

### rtl/encoder_bank_scanner.sv
// Encoder bank scanner, top level: APB registers, tick front end, plan queue, event back end.
// A tick word is taken whenever the plan queue (QUEUE_DEPTH ticks) has room,
// so ticks may arrive back to back. The first tick after reset only primes the previous
// pins. A tick that raises k events (0 to 2*ENCODERS) gives k event words, one per cycle
// while the receiver is ready; that output stage sets the sustained rate. Switch events come
// first, then rotation events, each by ascending encoder, and the final one has last_event.
// Depends on ebs_pkg, ebs_if, ebs_fifo, ebs_front and ebs_back.
module encoder_bank_scanner #(
  parameter int ENCODERS    = ebs_pkg::ENCODERS_DEF,
  parameter int PIN_BITS    = ebs_pkg::PIN_BITS_DEF,
  parameter int QUEUE_DEPTH = ebs_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  ebs_tick_if.sink                    tick,
  ebs_event_if.source                 evt,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ebs_pkg::ADDR_W-1:0]  paddr,
  input  logic [ebs_pkg::DATA_W-1:0]  pwdata,
  output logic [ebs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int EntryW = ENCODERS * (2 + ebs_pkg::CNT_W);

  ebs_pkg::ebs_cfg_t   cfg;
  ebs_pkg::ebs_reg_e   reg_sel;
  logic                push;
  logic                pop;
  logic                full;
  logic                empty;
  logic [EntryW-1:0]   entry;
  logic [EntryW-1:0]   qdata;

  assign pready  = 1'b1;
  assign reg_sel = ebs_pkg::ebs_reg_e'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.a_sel  <= ebs_pkg::A_SEL_RST;
      cfg.b_sel  <= ebs_pkg::B_SEL_RST;
      cfg.sw_sel <= ebs_pkg::SW_SEL_RST;
      cfg.flush  <= ebs_pkg::FLUSH_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        ebs_pkg::REG_A_SEL:  cfg.a_sel  <= pwdata[ebs_pkg::SEL_W-1:0];
        ebs_pkg::REG_B_SEL:  cfg.b_sel  <= pwdata[ebs_pkg::SEL_W-1:0];
        ebs_pkg::REG_SW_SEL: cfg.sw_sel <= pwdata[ebs_pkg::SEL_W-1:0];
        ebs_pkg::REG_FLUSH:  cfg.flush  <= pwdata[ebs_pkg::FLUSH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      ebs_pkg::REG_A_SEL:  prdata = ebs_pkg::DATA_W'(cfg.a_sel);
      ebs_pkg::REG_B_SEL:  prdata = ebs_pkg::DATA_W'(cfg.b_sel);
      ebs_pkg::REG_SW_SEL: prdata = ebs_pkg::DATA_W'(cfg.sw_sel);
      ebs_pkg::REG_FLUSH:  prdata = ebs_pkg::DATA_W'(cfg.flush);
      default:             prdata = '0;
    endcase
  end

  ebs_front #(
    .ENCODERS (ENCODERS),
    .PIN_BITS (PIN_BITS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .tick  (tick),
    .cfg   (cfg),
    .full  (full),
    .push  (push),
    .entry (entry)
  );

  ebs_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (EntryW)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (entry),
    .full  (full),
    .pop   (pop),
    .rdata (qdata),
    .empty (empty)
  );

  ebs_back #(
    .ENCODERS (ENCODERS)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .qdata (qdata),
    .empty (empty),
    .pop   (pop),
    .evt   (evt)
  );

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// testbench of encoder_bank_scanner: random and directed pin snapshots, predicted event words
// depends on ebs_pkg, ebs_if and the encoder_bank_scanner rtl
module tb_top;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 32;
  localparam int RX_HOLD       = 80;
  localparam int RUN_TICKS     = 16;
  localparam int PHASE_TICKS   = 42;

  typedef struct packed {
    logic                       kind;
    logic [ebs_pkg::IDX_W-1:0]  enc;
    logic [ebs_pkg::CNT_W-1:0]  steps;
    logic                       last_flag;
  } event_word_t;

  class scan_event_board;
    logic [ebs_pkg::SEL_W-1:0]   a_sel;
    logic [ebs_pkg::SEL_W-1:0]   b_sel;
    logic [ebs_pkg::SEL_W-1:0]   sw_sel;
    logic [ebs_pkg::FLUSH_W-1:0] flush_ticks;
    logic [ebs_pkg::SNAP_W-1:0]  prev_pins;
    bit                          primed;
    logic [ebs_pkg::CNT_W-1:0]   counts [ebs_pkg::ENCODERS_DEF];
    logic [ebs_pkg::FLUSH_W-1:0] idle_ticks;
    event_word_t                 pending_events [$];
    int                          errors;

    function new();
      a_sel = ebs_pkg::A_SEL_RST;
      b_sel = ebs_pkg::B_SEL_RST;
      sw_sel = ebs_pkg::SW_SEL_RST;
      flush_ticks = ebs_pkg::FLUSH_RST;
      prev_pins = '0;
      primed = 1'b0;
      idle_ticks = '0;
      errors = 0;
      for (int e = 0; e < ebs_pkg::ENCODERS_DEF; e++) counts[e] = '0;
    endfunction

    function void set_reg(ebs_pkg::ebs_reg_e r, logic [ebs_pkg::DATA_W-1:0] v);
      case (r)
        ebs_pkg::REG_A_SEL:  a_sel = v[ebs_pkg::SEL_W-1:0];
        ebs_pkg::REG_B_SEL:  b_sel = v[ebs_pkg::SEL_W-1:0];
        ebs_pkg::REG_SW_SEL: sw_sel = v[ebs_pkg::SEL_W-1:0];
        default:             flush_ticks = v[ebs_pkg::FLUSH_W-1:0];
      endcase
    endfunction

    function bit pin_at(logic [ebs_pkg::SNAP_W-1:0] pins, logic [ebs_pkg::SEL_W-1:0] sel,
                        int e);
      return pins[sel[4*e +: ebs_pkg::PIN_IDX_W]];
    endfunction

    function int pending();
      return pending_events.size();
    endfunction

    function void note_tick(logic [ebs_pkg::SNAP_W-1:0] snap);
      logic [ebs_pkg::SNAP_W-1:0] rising;
      event_word_t w;
      event_word_t batch [$];
      if (!primed) begin
        prev_pins = snap;
        primed = 1'b1;
        return;
      end
      rising = ~prev_pins & snap;
      for (int e = 0; e < ebs_pkg::ENCODERS_DEF; e++) begin
        if (pin_at(rising, b_sel, e)) begin
          if (pin_at(snap, a_sel, e)) counts[e] = counts[e] - 1'b1;
          else counts[e] = counts[e] + 1'b1;
          idle_ticks = '0;
        end
      end
      for (int e = 0; e < ebs_pkg::ENCODERS_DEF; e++) begin
        if (pin_at(rising, sw_sel, e)) begin
          w.kind = ebs_pkg::EVT_SWITCH;
          w.enc = e[ebs_pkg::IDX_W-1:0];
          w.steps = '0;
          w.last_flag = 1'b0;
          batch.push_back(w);
        end
      end
      idle_ticks = idle_ticks + 1'b1;
      if (idle_ticks >= flush_ticks) begin
        for (int e = 0; e < ebs_pkg::ENCODERS_DEF; e++) begin
          if (counts[e] != '0) begin
            w.kind = ebs_pkg::EVT_ROTATION;
            w.enc = e[ebs_pkg::IDX_W-1:0];
            w.steps = counts[e];
            w.last_flag = 1'b0;
            batch.push_back(w);
            counts[e] = '0;
          end
        end
        idle_ticks = '0;
      end
      prev_pins = snap;
      foreach (batch[k]) begin
        w = batch[k];
        w.last_flag = (k == batch.size() - 1);
        pending_events.push_back(w);
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_word(logic kind, logic [ebs_pkg::IDX_W-1:0] enc,
                    logic [ebs_pkg::CNT_W-1:0] steps, logic last_flag);
      event_word_t w;
      if (pending_events.size() == 0) begin
        report($sformatf("unexpected word kind %0d enc %0d steps %0d last %0d",
                         kind, enc, $signed(steps), last_flag));
        return;
      end
      w = pending_events.pop_front();
      if (kind !== w.kind)
        report($sformatf("event_kind %0d, expected %0d", kind, w.kind));
      if (enc !== w.enc)
        report($sformatf("encoder_index %0d, expected %0d", enc, w.enc));
      if (steps !== w.steps)
        report($sformatf("step_count %0d, expected %0d",
                         $signed(steps), $signed(w.steps)));
      if (last_flag !== w.last_flag)
        report($sformatf("last_event %0d, expected %0d", last_flag, w.last_flag));
    endtask
  endclass

  logic                         clk;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [ebs_pkg::ADDR_W-1:0]   paddr;
  logic [ebs_pkg::DATA_W-1:0]   pwdata;
  logic [ebs_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  ebs_tick_if  tick_ch ();
  ebs_event_if evt_ch ();

  encoder_bank_scanner dut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_ch),
    .evt     (evt_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  scan_event_board sb;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;
  int  rx_hold_req = 0;
  int  cycle_count = 0;
  int  qphase [ebs_pkg::ENCODERS_DEF];
  bit  sw_level [ebs_pkg::ENCODERS_DEF];

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("encoder_bank_scanner regression: fail");
      $finish;
    end
  end

  // accepted words on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (evt_ch.valid && evt_ch.ready)
        sb.check_word(evt_ch.event_kind, evt_ch.encoder_index, evt_ch.step_count,
                      evt_ch.last_event);
      if (tick_ch.valid && tick_ch.ready) sb.note_tick(tick_ch.pin_snapshot);
    end
  end

  // event receiver with random stalls and requested long holds
  initial begin
    int served;
    served = 0;
    evt_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        evt_ch.ready <= 1'b0;
      end else if (rx_hold_req != served) begin
        served++;
        evt_ch.ready <= 1'b0;
        repeat (RX_HOLD - 1) @(posedge clk);
      end else begin
        evt_ch.ready <= rx_steady || ($urandom_range(99, 0) >= 6);
      end
    end
  end

  task automatic send_tick(input logic [ebs_pkg::SNAP_W-1:0] snap);
    while (!tx_steady && $urandom_range(99, 0) < 6) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.pin_snapshot <= snap;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
  endtask

  task automatic pause_until_drained();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input ebs_pkg::ebs_reg_e r,
                           input logic [ebs_pkg::DATA_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(r, v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [ebs_pkg::SEL_W-1:0] a,
                           input logic [ebs_pkg::SEL_W-1:0] b,
                           input logic [ebs_pkg::SEL_W-1:0] sw,
                           input logic [ebs_pkg::FLUSH_W-1:0] flush);
    pause_until_drained();
    apb_write(ebs_pkg::REG_A_SEL, ebs_pkg::DATA_W'(a));
    apb_write(ebs_pkg::REG_B_SEL, ebs_pkg::DATA_W'(b));
    apb_write(ebs_pkg::REG_SW_SEL, ebs_pkg::DATA_W'(sw));
    apb_write(ebs_pkg::REG_FLUSH, ebs_pkg::DATA_W'(flush));
  endtask

  // distinct pins for every A, B and switch input
  task automatic pick_selects(output logic [ebs_pkg::SEL_W-1:0] a,
                              output logic [ebs_pkg::SEL_W-1:0] b,
                              output logic [ebs_pkg::SEL_W-1:0] sw);
    logic [ebs_pkg::PIN_IDX_W-1:0] pins [16];
    logic [ebs_pkg::PIN_IDX_W-1:0] t;
    int j;
    for (int k = 0; k < 16; k++) pins[k] = k[ebs_pkg::PIN_IDX_W-1:0];
    for (int k = 15; k > 0; k--) begin
      j = int'($urandom_range(k, 0));
      t = pins[k];
      pins[k] = pins[j];
      pins[j] = t;
    end
    for (int k = 0; k < ebs_pkg::ENCODERS_DEF; k++) begin
      a[4*k +: ebs_pkg::PIN_IDX_W] = pins[k];
      b[4*k +: ebs_pkg::PIN_IDX_W] = pins[k+5];
      sw[4*k +: ebs_pkg::PIN_IDX_W] = pins[k+10];
    end
  endtask

  // gray-code walk per encoder, unused pins random
  function automatic logic [ebs_pkg::SNAP_W-1:0] next_snapshot(bit quiet, int move_pct);
    logic [ebs_pkg::SNAP_W-1:0] s;
    int r;
    s = ebs_pkg::SNAP_W'($urandom_range(16'hFFFF, 0));
    for (int e = 0; e < ebs_pkg::ENCODERS_DEF; e++) begin
      if (!quiet) begin
        r = int'($urandom_range(99, 0));
        if (r < move_pct) qphase[e] = (qphase[e] + 1) % 4;
        else if (r < 2 * move_pct) qphase[e] = (qphase[e] + 3) % 4;
      end
      if ($urandom_range(7, 0) == 0) sw_level[e] = !sw_level[e];
      s[sb.a_sel[4*e +: ebs_pkg::PIN_IDX_W]] = (qphase[e] == 1 || qphase[e] == 2);
      s[sb.b_sel[4*e +: ebs_pkg::PIN_IDX_W]] = (qphase[e] >= 2);
      s[sb.sw_sel[4*e +: ebs_pkg::PIN_IDX_W]] = sw_level[e];
    end
    return s;
  endfunction

  initial begin
    logic [ebs_pkg::SEL_W-1:0]   a;
    logic [ebs_pkg::SEL_W-1:0]   b;
    logic [ebs_pkg::SEL_W-1:0]   sw;
    logic [ebs_pkg::FLUSH_W-1:0] flush;
    logic [ebs_pkg::SNAP_W-1:0]  snap;
    int move_pct;
    int quiet_left;
    sb = new();
    for (int e = 0; e < ebs_pkg::ENCODERS_DEF; e++) begin
      qphase[e] = 0;
      sw_level[e] = 1'b0;
    end
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tick_ch.valid = 1'b0;
    tick_ch.pin_snapshot = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset config: priming tick, then all pins rising at once
    send_tick(16'hFFFF);
    send_tick(16'h0000);
    send_tick(16'hFFFF);
    send_tick(16'h0000);

    // everything on pin 0, flush on every tick
    configure(20'h00000, 20'h00000, 20'h00000, 16'd0);
    send_tick(16'h0001);
    send_tick(16'h0000);
    send_tick(16'h0001);
    send_tick(16'hFFFE);
    send_tick(16'hFFFF);

    // A and switch on pin 15, B on pin 0
    configure(20'hFFFFF, 20'h00000, 20'hFFFFF, 16'd1);
    send_tick(16'h0000);
    send_tick(16'h8001);
    send_tick(16'h0000);
    send_tick(16'h0001);
    send_tick(16'h8000);
    send_tick(16'h0000);

    pick_selects(a, b, sw);
    configure(a, b, sw, 16'd2);
    repeat (8) send_tick(next_snapshot(1'b0, 40));

    for (int ph = 0; ph < 8; ph++) begin
      pick_selects(a, b, sw);
      if (ph == 5) begin
        a = ebs_pkg::SEL_W'($urandom_range(20'hFFFFF, 0));
        b = ebs_pkg::SEL_W'($urandom_range(20'hFFFFF, 0));
        sw = ebs_pkg::SEL_W'($urandom_range(20'hFFFFF, 0));
      end
      case (ph)
        0: flush = 16'd1;
        1: flush = 16'd2;
        2: flush = ebs_pkg::FLUSH_W'($urandom_range(6, 3));
        3: flush = 16'hFFFF;
        4: flush = ebs_pkg::FLUSH_W'($urandom_range(12, 1));
        6: flush = 16'd2;
        default: flush = ebs_pkg::FLUSH_W'($urandom_range(4, 1));
      endcase
      configure(a, b, sw, flush);
      tx_steady = (ph == 6);
      rx_steady = (ph == 6);
      move_pct = int'($urandom_range(30, 8));
      quiet_left = 0;
      for (int i = 0; i < PHASE_TICKS; i++) begin
        if (ph == 2 && i == 10) rx_hold_req++;
        if (ph == 4 && i == 20) pause_until_drained();
        if (quiet_left > 0) begin
          quiet_left--;
          snap = next_snapshot(1'b1, move_pct);
        end else if ($urandom_range(99, 0) < 12) begin
          snap = ebs_pkg::SNAP_W'($urandom_range(16'hFFFF, 0));
        end else begin
          if ($urandom_range(99, 0) < 10) quiet_left = int'($urandom_range(12, 1));
          snap = next_snapshot(1'b0, move_pct);
        end
        send_tick(snap);
      end
      tx_steady = 1'b0;
      rx_steady = 1'b0;
    end

    // shared B pin steps every encoder at once, opposite directions, then flush
    configure(20'h22221, 20'h00000, 20'hFFFFF, 16'd3);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (4) send_tick(16'h0004);
    for (int i = 0; i < RUN_TICKS; i++) send_tick(i[0] ? 16'h0004 : 16'h0005);
    repeat (4) send_tick(16'h0004);
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    pause_until_drained();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("encoder_bank_scanner regression: pass");
    else
      $display("encoder_bank_scanner regression: fail");
    $finish;
  end

endmodule
